/* rtl/pnguf_pkg.sv */
// Shared types and constants for the PNG row unfilter (RGBA, 8 bits per channel).
// No dependencies; imported by every module of the block.
package pnguf_pkg;

    localparam int MAX_WIDTH       = 512;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int LINE_BYTES      = MAX_WIDTH * BYTES_PER_PIXEL;
    localparam int COL_W           = $clog2(LINE_BYTES);

    localparam int WIDTH_REG_W  = 10;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_DATA_W   = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] FILTER_MAX = 8'd4;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // one classified pixel byte, front to back
    typedef struct packed {
        logic [7:0]       data;
        logic [COL_W-1:0] col;
        filter_t          filt;
        logic             first_row;
        logic             row_start;
        logic             row_end;
        logic             image_end;
        logic             err;
    } pix_item_t;

endpackage

/* rtl/png_row_unfilter_rgba8_top.sv */
// PNG row unfilter for 8-bit RGBA: top level joining front end, queue and back end.
// Depends on pnguf_pkg, pnguf_front, pnguf_queue and pnguf_back.
//
// Input channel: one inflated byte per item on stream_byte (byte_valid/byte_stall).
// The first byte of each row is the filter type and yields no output; every
// pixel byte yields one item on the output channel (pix_valid/pix_stall) with
// the reconstructed byte, its channel, row and image end marks and the sticky
// bad_filter flag. Filter codes above 4 set bad_filter; later bytes pass
// through unchanged.
// Throughput: one byte per cycle while byte_stall is low, filter bytes included.
// A pixel byte passes through the queue, then the line store read, then
// reconstruction into the output register.
// The four-entry queue decouples framing from reconstruction; byte_stall rises
// only when the queue is full, so an output stall stops input after the queue
// and the two back end stages fill up.
// Reset: framing restarts at a filter byte, width and height go to 1, the error
// flag behind bad_filter clears (its output register is not reset). The line store
// is not cleared; the first row of each image sees zero above, so no clearing pass is needed.
// Configuration: cfg_wr_en writes image_width (index 0) or image_height (index 1).
module png_row_unfilter_rgba8_top
    import pnguf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  logic [7:0]            stream_byte,
    output logic                  pix_valid,
    input  logic                  pix_stall,
    output logic [7:0]            pixel_byte,
    output logic [1:0]            channel,
    output logic                  last_in_row,
    output logic                  last_in_image,
    output logic                  bad_filter
);

    logic      accept;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_nonempty;
    pix_item_t front_item;
    pix_item_t head_item;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    pnguf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .stream_byte (stream_byte),
        .push        (q_push),
        .item        (front_item)
    );

    pnguf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (head_item),
        .nonempty  (q_nonempty),
        .full      (q_full)
    );

    pnguf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_item     (head_item),
        .nonempty      (q_nonempty),
        .pop           (q_pop),
        .pix_stall     (pix_stall),
        .pix_valid     (pix_valid),
        .pixel_byte    (pixel_byte),
        .channel       (channel),
        .last_in_row   (last_in_row),
        .last_in_image (last_in_image),
        .bad_filter    (bad_filter)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
        else $error("queue pop while empty");

    a_image_end_in_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> (!last_in_image || last_in_row))
        else $error("image end without row end");

    a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && bad_filter) |=> (!pix_valid || bad_filter))
        else $error("bad_filter cleared after being set");

endmodule

/* rtl/pnguf_front.sv */
// Front end: configuration registers, row and image framing, filter byte decode.
// Depends on pnguf_pkg; feeds classified pixel items to pnguf_queue.
module pnguf_front
    import pnguf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [7:0]            stream_byte,
    output logic                  push,
    output pix_item_t             item
);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    awaiting_reg;
    logic                    row_start_reg;
    logic                    first_row_reg;
    logic                    err_reg;
    filter_t                 filt_reg;
    logic [COL_W-1:0]        col_reg;
    logic [HEIGHT_REG_W-1:0] row_reg;

    logic [15:0]             width_eff;
    logic [15:0]             last_col;
    logic [COL_W-1:0]        col;
    logic [HEIGHT_REG_W-1:0] last_row;
    logic                    row_end;
    logic                    image_end;
    logic                    bad_code;

    always_comb
    begin
        width_eff = 16'(width_reg);
        if (width_reg == '0)
        begin
            width_eff = 16'd1;
        end
        else if (width_eff > 16'(MAX_WIDTH))
        begin
            width_eff = 16'(MAX_WIDTH);
        end
        last_col = 16'(width_eff << 2) - 16'd1;
        // clamp a column that ran past a shrunken row
        if (16'(col_reg) >= last_col)
        begin
            col = last_col[COL_W-1:0];
        end
        else
        begin
            col = col_reg;
        end
        last_row  = (height_reg == '0) ? '0 : height_reg - 1'b1;
        row_end   = (16'(col) >= last_col);
        image_end = row_end && (row_reg >= last_row);
        bad_code  = (stream_byte > FILTER_MAX);
    end

    assign push = accept && !awaiting_reg;

    always_comb
    begin
        item.data      = stream_byte;
        item.col       = col;
        item.filt      = filt_reg;
        item.first_row = first_row_reg;
        item.row_start = row_start_reg;
        item.row_end   = row_end;
        item.image_end = image_end;
        item.err       = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(1);
            height_reg <= HEIGHT_REG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            row_start_reg <= 1'b0;
            first_row_reg <= 1'b1;
            err_reg       <= 1'b0;
            filt_reg      <= FILT_NONE;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else if (accept)
        begin
            if (awaiting_reg)
            begin
                // filter byte: decode and open the row
                if (bad_code)
                begin
                    err_reg  <= 1'b1;
                    filt_reg <= FILT_NONE;
                end
                else
                begin
                    filt_reg <= filter_t'(stream_byte[2:0]);
                end
                col_reg       <= '0;
                awaiting_reg  <= 1'b0;
                row_start_reg <= 1'b1;
            end
            else
            begin
                row_start_reg <= 1'b0;
                if (row_end)
                begin
                    awaiting_reg <= 1'b1;
                    col_reg      <= '0;
                    if (image_end)
                    begin
                        row_reg       <= '0;
                        first_row_reg <= 1'b1;
                    end
                    else
                    begin
                        row_reg       <= row_reg + 1'b1;
                        first_row_reg <= 1'b0;
                    end
                end
                else
                begin
                    col_reg <= col + 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/pnguf_queue.sv */
// Short item queue between the front end and the reconstruction back end.
// Depends on pnguf_pkg for the item type and depth.
module pnguf_queue
    import pnguf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pix_item_t push_item,
    input  logic      pop,
    output pix_item_t head_item,
    output logic      nonempty,
    output logic      full
);

    pix_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign head_item = slot_reg[rd_ptr_reg];
    assign nonempty  = (count_reg != '0);
    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/pnguf_back.sv */
// Back end: line store read, byte reconstruction (sub, up, average, Paeth) and
// the output register. Depends on pnguf_pkg; pulls items from pnguf_queue.
module pnguf_back
    import pnguf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pix_item_t  head_item,
    input  logic       nonempty,
    output logic       pop,
    input  logic       pix_stall,
    output logic       pix_valid,
    output logic [7:0] pixel_byte,
    output logic [1:0] channel,
    output logic       last_in_row,
    output logic       last_in_image,
    output logic       bad_filter
);

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] d_bc;
        logic signed [9:0] d_ac;
        logic signed [9:0] d_sum;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        d_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
        d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
        d_sum = d_bc + d_ac;
        pa    = (d_bc < 0) ? 10'(-d_bc) : 10'(d_bc);
        pb    = (d_ac < 0) ? 10'(-d_ac) : 10'(d_ac);
        pc    = (d_sum < 0) ? 10'(-d_sum) : 10'(d_sum);
        if (pa <= pb && pa <= pc)
        begin
            return a;
        end
        else if (pb <= pc)
        begin
            return b;
        end
        return c;
    endfunction

    logic [7:0]     line_mem [LINE_BYTES];
    logic [7:0]     rdata_reg;

    logic           a_valid_reg;
    pix_item_t      a_item_reg;
    logic           a_adv;

    logic [7:0]     left_reg [BYTES_PER_PIXEL];
    logic [7:0]     ul_reg [BYTES_PER_PIXEL];
    logic [3:0]     lv_reg;

    logic           out_valid_reg;
    logic [7:0]     pixel_reg;
    logic [1:0]     ch_reg;
    logic           last_row_reg;
    logic           last_img_reg;
    logic           bad_reg;

    logic [1:0]     ch;
    logic           lv_hit;
    logic [7:0]     left;
    logic [7:0]     above_left;
    logic [7:0]     above;
    logic [8:0]     avg_sum;
    logic [7:0]     pred;
    logic [7:0]     value;
    logic [3:0]     ch_mask;

    assign a_adv = a_valid_reg && (!out_valid_reg || !pix_stall);
    assign pop   = nonempty && (!a_valid_reg || a_adv);

    always_comb
    begin
        ch         = a_item_reg.col[1:0];
        ch_mask    = 4'b0001 << ch;
        // left and upper-left read as zero until written in this row
        lv_hit     = lv_reg[ch] && !a_item_reg.row_start;
        left       = lv_hit ? left_reg[ch] : 8'd0;
        above_left = lv_hit ? ul_reg[ch] : 8'd0;
        above      = a_item_reg.first_row ? 8'd0 : rdata_reg;
        avg_sum    = {1'b0, left} + {1'b0, above};
        pred       = 8'd0;
        if (!a_item_reg.err)
        begin
            unique case (a_item_reg.filt)
                FILT_NONE:  pred = 8'd0;
                FILT_SUB:   pred = left;
                FILT_UP:    pred = above;
                FILT_AVG:   pred = avg_sum[8:1];
                FILT_PAETH: pred = paeth(left, above, above_left);
                default:    pred = 8'd0;
            endcase
        end
        value = a_item_reg.data + pred;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            line_mem[a_item_reg.col] <= value;
        end
        if (pop)
        begin
            rdata_reg <= line_mem[head_item.col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_item_reg <= head_item;
        end
        if (a_adv)
        begin
            left_reg[ch] <= value;
            ul_reg[ch]   <= above;
            pixel_reg    <= value;
            ch_reg       <= ch;
            last_row_reg <= a_item_reg.row_end;
            last_img_reg <= a_item_reg.image_end;
            bad_reg      <= a_item_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            lv_reg        <= '0;
        end
        else
        begin
            if (pop)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                out_valid_reg <= 1'b1;
                lv_reg        <= (a_item_reg.row_start ? 4'b0000 : lv_reg) | ch_mask;
            end
            else if (!pix_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pix_valid     = out_valid_reg;
    assign pixel_byte    = pixel_reg;
    assign channel       = ch_reg;
    assign last_in_row   = last_row_reg;
    assign last_in_image = last_img_reg;
    assign bad_filter    = bad_reg;

endmodule
